// ----- hdl/ssao_pkg.sv -----
// Shared types, constants and sample-offset tables for the ambient occlusion block.
// No dependencies; every other file imports this package.
package ssao_pkg;

  // Request kinds on the input channel
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_THRESH   = 2'd2,
    REG_STRENGTH = 2'd3
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_CFG_W  = 10;
  localparam int POS_W      = 9;
  localparam int DEPTH_W    = 32;
  localparam int CNT_W      = 7;
  localparam int STR_W      = 16;
  localparam int PROD_W     = STR_W + CNT_W;     // strength * occluded count
  localparam int NUM_W      = PROD_W + 8;        // times 255
  localparam int REM_W      = NUM_W + 1;         // numerator plus rounding term
  localparam int DSH_W      = CNT_W + 16 + 7;    // divisor shifted to top quotient bit
  localparam int Q_W        = 8;
  localparam int NUM_SAMPLES = 64;
  localparam logic [7:0] FULL_BRIGHT = 8'd255;

  // Reset values of the configuration registers
  localparam logic [DIM_CFG_W-1:0] RST_WIDTH    = 10'd512;
  localparam logic [DIM_CFG_W-1:0] RST_HEIGHT   = 10'd512;
  localparam logic [STR_W-1:0]     RST_THRESH   = 16'd66;
  localparam logic [STR_W-1:0]     RST_STRENGTH = 16'd22938;

  // One depth store entry
  typedef struct packed {
    logic               empty;
    logic [DEPTH_W-1:0] depth;
  } depth_entry_t;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic [DIM_CFG_W-1:0] image_width;
    logic [DIM_CFG_W-1:0] image_height;
    logic [STR_W-1:0]     threshold;
    logic [STR_W-1:0]     strength;
  } cfg_t;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SAMPLE,
    ST_DRAIN,
    ST_MUL,
    ST_SCALE,
    ST_DIVGO,
    ST_DIV_DONE
  } state_t;

  // Axis component of a sample direction
  typedef enum logic [2:0] {
    AX_ZERO,
    AX_POS,
    AX_NEG,
    DG_POS,
    DG_NEG
  } axis_code_t;

  typedef logic signed [5:0] off_t;

  // Rounded diagonal offsets, radius 2*(s+1) times cos 45
  localparam off_t DIAG_OFF [8] = '{6'sd1, 6'sd3, 6'sd4, 6'sd6, 6'sd7, 6'sd8, 6'sd10, 6'sd11};

  localparam axis_code_t DIR_X [8] = '{AX_POS, DG_POS, AX_ZERO, DG_NEG,
                                       AX_NEG, DG_NEG, AX_ZERO, DG_POS};
  localparam axis_code_t DIR_Y [8] = '{AX_ZERO, DG_POS, AX_POS, DG_POS,
                                       AX_ZERO, DG_NEG, AX_NEG, DG_NEG};

  // Offset along one axis for direction code and radius step
  function automatic off_t axis_offset(axis_code_t code, logic [2:0] step);
    off_t radius;
    radius = off_t'({2'b00, step, 1'b0}) + 6'sd2;
    unique case (code)
      AX_POS:  axis_offset = radius;
      AX_NEG:  axis_offset = -radius;
      DG_POS:  axis_offset = DIAG_OFF[step];
      DG_NEG:  axis_offset = -DIAG_OFF[step];
      default: axis_offset = 6'sd0;
    endcase
  endfunction

endpackage

// ----- hdl/screen_space_ambient_occlusion.sv -----
// Screen-space ambient occlusion over a stored depth image. Top level: configuration
// registers, depth memory and request sequencer. Uses ssao_pkg, ssao_depth_mem, ssao_seq.
//
// A write request stores one depth pixel. A query request reads its centre pixel,
// then walks 64 fixed offsets (8 directions, radii 2..16) through the single read
// port of the depth memory at one sample per cycle, and scales the occluded/sample
// ratio with a restoring divider. A query whose centre lies outside the image ends
// without a memory read, one with an empty centre after the centre read, and one
// with no sample inside the image before the divider. A full query holds the input
// through the centre read, 64 memory reads, counting and scaling, the divider and
// the hand-off. A stalled output delays the loading of the next query result. One
// request is in work at a time; a finished result waits in the output register while
// the next request is taken. The depth memory has no reset and needs no clearing
// pass: every pixel must be written before it is queried. Configuration may be
// written only while idle.
module screen_space_ambient_occlusion
  import ssao_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [POS_W-1:0]          in_pos_x,
  input  logic [POS_W-1:0]          in_pos_y,
  input  logic signed [DEPTH_W-1:0] in_depth_value,
  input  logic                      in_is_empty,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_ao_intensity,
  output logic [CNT_W-1:0]          out_occluded_count,
  output logic [CNT_W-1:0]          out_sample_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CW      = ((DIM_W > POS_W + 1) ? DIM_W : POS_W + 1) + 1;

  cfg_t         cfg_r;
  logic         wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  depth_entry_t wr_data, rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_WIDTH;
      cfg_r.image_height <= RST_HEIGHT;
      cfg_r.threshold    <= RST_THRESH;
      cfg_r.strength     <= RST_STRENGTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    cfg_r.image_width  <= cfg_data[DIM_CFG_W-1:0];
        REG_HEIGHT:   cfg_r.image_height <= cfg_data[DIM_CFG_W-1:0];
        REG_THRESH:   cfg_r.threshold    <= cfg_data;
        REG_STRENGTH: cfg_r.strength     <= cfg_data;
        default:      cfg_r.strength     <= cfg_r.strength;
      endcase
    end
  end

  ssao_depth_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssao_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_depth_value     (in_depth_value),
    .in_is_empty        (in_is_empty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ao_intensity   (out_ao_intensity),
    .out_occluded_count (out_occluded_count),
    .out_sample_count   (out_sample_count),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data)
  );

endmodule

// ----- hdl/ssao_depth_mem.sv -----
// Depth store: single-port-write, single-port-read synchronous memory.
// Read data registered. Uses ssao_pkg for the entry type.
module ssao_depth_mem
  import ssao_pkg::*;
#(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic         clk,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  depth_entry_t wr_data,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output depth_entry_t rd_data
);

  depth_entry_t mem [DEPTH];
  depth_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/ssao_div.sv -----
// Restoring divider: ceil(num / (total * 65536)), one quotient bit per cycle.
// Depends on ssao_pkg widths.
module ssao_div
  import ssao_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [CNT_W-1:0] total,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0] dsh_r, dsh_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic             fits;

  // Compare remainder against shifted divisor
  assign fits = rem_r >= REM_W'(dsh_r);

  // Step the division
  always_comb begin
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      rem_nxt    = REM_W'(num) + REM_W'({total, 16'h0000}) - REM_W'(1);
      dsh_nxt    = {total, 16'h0000, 7'h00};
      q_nxt      = '0;
      cnt_nxt    = 4'd8;
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (fits) begin
        rem_nxt = rem_r - REM_W'(dsh_r);
      end
      q_nxt   = {q_r[Q_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- hdl/ssao_seq.sv -----
// Request sequencer: stores writes, walks the 64 sample offsets of a query through
// the depth memory read port, counts and scales. Uses ssao_pkg and ssao_div.
module ssao_seq
  import ssao_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int AW         = 18,
  parameter int CW         = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [POS_W-1:0]          in_pos_x,
  input  logic [POS_W-1:0]          in_pos_y,
  input  logic signed [DEPTH_W-1:0] in_depth_value,
  input  logic                      in_is_empty,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_ao_intensity,
  output logic [CNT_W-1:0]          out_occluded_count,
  output logic [CNT_W-1:0]          out_sample_count,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output depth_entry_t              wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  depth_entry_t              rd_data
);

  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [CW-1:0] MAXW_C     = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] MAXH_C     = CW'(MAX_HEIGHT);

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      px_r, py_r;
  logic signed [DEPTH_W+1:0] cref_r;
  logic [5:0]            idx_r;
  logic                  pend_r;
  logic [CNT_W-1:0]      occ_r, tot_r;
  logic [PROD_W-1:0]     prod_r;
  logic [NUM_W-1:0]      num_r;
  logic [Q_W-1:0]        q_r;
  logic                  full_r;
  logic                  div_wait_r;
  logic                  out_valid_r;
  logic [7:0]            out_ao_r;
  logic [CNT_W-1:0]      out_occ_r, out_tot_r;

  logic [CW-1:0]         w_cl, h_cl;
  logic [CW-1:0]         in_x_c, in_y_c;
  logic                  in_acc, is_query, centre_in, write_ok;
  logic signed [CW-1:0]  sx, sy;
  off_t                  ox, oy;
  logic                  inb;
  logic                  out_load;
  logic                  smp_occ;
  logic                  div_start, div_done;
  logic [Q_W-1:0]        div_q;

  // Map a pixel to its store address
  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] xv, logic [CW-1:0] yv);
    addr_of = AW'(AW'(yv) * ROW_STRIDE + AW'(xv));
  endfunction

  // Clamp image size to the store
  assign w_cl = (CW'(cfg.image_width) > MAXW_C) ? MAXW_C : CW'(cfg.image_width);
  assign h_cl = (CW'(cfg.image_height) > MAXH_C) ? MAXH_C : CW'(cfg.image_height);

  assign in_x_c    = CW'(in_pos_x);
  assign in_y_c    = CW'(in_pos_y);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign is_query  = (in_kind == KIND_QUERY);
  assign centre_in = (in_x_c < w_cl) && (in_y_c < h_cl);
  assign write_ok  = (in_x_c < MAXW_C) && (in_y_c < MAXH_C);

  // Sample position for the current offset index
  assign ox  = axis_offset(DIR_X[idx_r[5:3]], idx_r[2:0]);
  assign oy  = axis_offset(DIR_Y[idx_r[5:3]], idx_r[2:0]);
  assign sx  = $signed(CW'(px_r)) + CW'(ox);
  assign sy  = $signed(CW'(py_r)) + CW'(oy);
  assign inb = !sx[CW-1] && !sy[CW-1] && ($unsigned(sx) < w_cl) && ($unsigned(sy) < h_cl);

  // Occluder test on returned sample
  assign smp_occ = !rd_data.empty &&
                   ($signed({{2{rd_data.depth[DEPTH_W-1]}}, rd_data.depth}) < cref_r);

  // Hold the result until the divider has handed over its quotient and the output register is free
  assign out_load = (state_r == ST_DIV_DONE) && !div_wait_r && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = centre_in ? ST_CENTRE : ST_DIV_DONE;
        end
      end
      ST_CENTRE: begin
        state_nxt = rd_data.empty ? ST_DIV_DONE : ST_SAMPLE;
      end
      ST_SAMPLE: begin
        if (idx_r == 6'd63) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_MUL;
      ST_MUL:    state_nxt = (tot_r == '0) ? ST_DIV_DONE : ST_SCALE;
      ST_SCALE:  state_nxt = ST_DIVGO;
      ST_DIVGO:  state_nxt = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    wr_en     = in_acc && !is_query && write_ok;
    wr_addr   = addr_of(in_x_c, in_y_c);
    wr_data   = '{empty: in_is_empty, depth: in_depth_value};
    rd_en     = (in_acc && is_query && centre_in) || ((state_r == ST_SAMPLE) && inb);
    rd_addr   = (state_r == ST_IDLE) ? addr_of(in_x_c, in_y_c)
                                     : addr_of($unsigned(sx), $unsigned(sy));
    div_start = (state_r == ST_DIVGO);
  end

  ssao_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .total (tot_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      div_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SAMPLE) && inb;
      // Track the divider from start until its quotient is latched
      if (div_start) begin
        div_wait_r <= 1'b1;
      end else if (div_done) begin
        div_wait_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Latch query centre
    if (in_acc && is_query) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      full_r <= !centre_in;
    end
    // Centre depth arrives: set compare level, clear counts
    if (state_r == ST_CENTRE) begin
      cref_r <= $signed({{2{rd_data.depth[DEPTH_W-1]}}, rd_data.depth})
                - $signed({2'b00, 16'h0000, cfg.threshold});
      full_r <= rd_data.empty;
      occ_r  <= '0;
      tot_r  <= '0;
      idx_r  <= '0;
    end
    // Advance offset index
    if (state_r == ST_SAMPLE) begin
      idx_r <= idx_r + 6'd1;
    end
    // Count returned sample
    if (pend_r) begin
      tot_r <= tot_r + CNT_W'(1);
      if (smp_occ) begin
        occ_r <= occ_r + CNT_W'(1);
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(cfg.strength) * PROD_W'(occ_r);
      full_r <= (tot_r == '0);
    end
    if (state_r == ST_SCALE) begin
      num_r <= {prod_r, 8'h00} - NUM_W'(prod_r);
    end
    if (div_done) begin
      q_r <= div_q;
    end
    // Load result register
    if (out_load) begin
      if (full_r) begin
        out_ao_r  <= FULL_BRIGHT;
        out_occ_r <= '0;
        out_tot_r <= '0;
      end else begin
        out_ao_r  <= FULL_BRIGHT - q_r;
        out_occ_r <= occ_r;
        out_tot_r <= tot_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ao_intensity   = out_ao_r;
  assign out_occluded_count = out_occ_r;
  assign out_sample_count   = out_tot_r;

  // Counts stay consistent
  a_occ_le_tot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMPLE || state_r == ST_DRAIN || state_r == ST_MUL) |-> occ_r <= tot_r)
    else $error("occluded count exceeds sample count");

  a_tot_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> tot_r <= CNT_W'(NUM_SAMPLES))
    else $error("sample count above 64");

  a_first_sample_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMPLE && idx_r == 6'd0) |-> (tot_r == '0 && occ_r == '0))
    else $error("counts not cleared at sample start");

  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r) == ST_SAMPLE)
    else $error("sample return without a sample read");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVGO) |=> ##8 div_done)
    else $error("divider did not finish in eight cycles");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for screen_space_ambient_occlusion: random and directed depth
// writes and occlusion queries, with a built-in predictor of the intensity and counts.
// Depends on ssao_pkg and the block's RTL only.
module tb_top;
  import ssao_pkg::*;

  localparam int STORE_DIM    = 512;
  localparam int STORE_CELLS  = STORE_DIM * STORE_DIM;
  localparam int REGION       = 24;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_TARGET  = 1300;
  localparam int PHASE_ITEMS  = 120;
  localparam int REPORT_LIMIT = 10;
  localparam int LIMIT_CYCLES = 1000000;

  // Sample pattern: eight directions, radius 2..16, rounded diagonal reach
  localparam int DIAG_REACH [8] = '{1, 3, 4, 6, 7, 8, 10, 11};
  localparam int DIR_SX [8]     = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int DIR_SY [8]     = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct {
    kind_t              kind;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [DEPTH_W-1:0] depth;
    logic               empty;
  } pixel_req_t;

  typedef struct {
    logic [7:0]       ao;
    logic [CNT_W-1:0] occ;
    logic [CNT_W-1:0] cnt;
  } ao_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_WRITE;
  logic [POS_W-1:0] in_pos_x = '0;
  logic [POS_W-1:0] in_pos_y = '0;
  logic signed [DEPTH_W-1:0] in_depth_value = '0;
  logic in_is_empty = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_ao_intensity;
  logic [CNT_W-1:0] out_occluded_count;
  logic [CNT_W-1:0] out_sample_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadows, depth mirror and the fill map used to keep queries legal
  logic [DIM_CFG_W-1:0] img_w = RST_WIDTH;
  logic [DIM_CFG_W-1:0] img_h = RST_HEIGHT;
  logic [STR_W-1:0] thresh = RST_THRESH;
  logic [STR_W-1:0] strength = RST_STRENGTH;
  logic signed [DEPTH_W-1:0] depth_mirror [STORE_CELLS];
  bit empty_mirror [STORE_CELLS];
  bit filled [STORE_CELLS];
  logic [DEPTH_W-1:0] depth_base;

  pixel_req_t pending_reqs [$];
  ao_result_t expected_results [$];
  pixel_req_t cur_req;
  ao_result_t got_result;
  ao_result_t want_result;
  int items_issued = 0;
  int mismatches = 0;
  int hold_count = 0;
  int phase_no;
  logic steady = 1'b0;
  logic hold_req = 1'b0;

  screen_space_ambient_occlusion #(
    .MAX_WIDTH (STORE_DIM),
    .MAX_HEIGHT(STORE_DIM)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_depth_value    (in_depth_value),
    .in_is_empty       (in_is_empty),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ao_intensity  (out_ao_intensity),
    .out_occluded_count(out_occluded_count),
    .out_sample_count  (out_sample_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [DIM_CFG_W-1:0] v);
    return (v > STORE_DIM) ? STORE_DIM : int'(v);
  endfunction

  function automatic void ring_offset(input int dir, input int step, output int dx,
                                      output int dy);
    int reach;
    reach = (dir % 2 == 1) ? DIAG_REACH[step] : 2 * (step + 1);
    dx = DIR_SX[dir] * reach;
    dy = DIR_SY[dir] * reach;
  endfunction

  // Occlusion of one centre pixel against the mirrored depth image
  function automatic ao_result_t occlusion_at(input int px, input int py);
    ao_result_t res;
    int weff, heff, sx, sy, dx, dy, addr;
    int unsigned occ, total;
    longint centre, limit, sample;
    longint unsigned num, den;
    res.ao = FULL_BRIGHT;
    res.occ = '0;
    res.cnt = '0;
    weff = eff_dim(img_w);
    heff = eff_dim(img_h);
    if (px >= weff || py >= heff) return res;
    addr = py * STORE_DIM + px;
    if (empty_mirror[addr]) return res;
    centre = depth_mirror[addr];
    limit = centre - longint'(thresh);
    occ = 0;
    total = 0;
    for (int d = 0; d < 8; d++) begin
      for (int s = 0; s < 8; s++) begin
        ring_offset(d, s, dx, dy);
        sx = px + dx;
        sy = py + dy;
        if (sx < 0 || sy < 0 || sx >= weff || sy >= heff) continue;
        total++;
        addr = sy * STORE_DIM + sx;
        if (empty_mirror[addr]) continue;
        sample = depth_mirror[addr];
        if (sample < limit) occ++;
      end
    end
    if (total != 0) begin
      num = 64'd255 * strength * occ;
      den = 64'd65536 * total;
      res.ao = 8'(64'd255 - (num + den - 64'd1) / den);
      res.occ = CNT_W'(occ);
      res.cnt = CNT_W'(total);
    end
    return res;
  endfunction

  // Apply an accepted request to the mirror, or queue its expected answer
  function automatic void commit_request(input pixel_req_t r);
    int addr;
    addr = int'(r.y) * STORE_DIM + int'(r.x);
    if (r.kind == KIND_WRITE) begin
      depth_mirror[addr] = r.depth;
      empty_mirror[addr] = r.empty;
    end else begin
      expected_results.push_back(occlusion_at(int'(r.x), int'(r.y)));
    end
  endfunction

  // Depths cluster around a base so that the threshold decides often
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned r, amp;
    r = $urandom_range(0, 99);
    amp = 300 + 2 * thresh;
    if (r < 60) return depth_base + DEPTH_W'($urandom_range(0, 2 * amp)) - DEPTH_W'(amp);
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic pick_empty();
    return $urandom_range(0, 99) < 15;
  endfunction

  task automatic add_write(input int x, input int y, input logic [DEPTH_W-1:0] depth,
                           input logic empty);
    pixel_req_t r;
    r.kind = KIND_WRITE;
    r.x = POS_W'(x);
    r.y = POS_W'(y);
    r.depth = depth;
    r.empty = empty;
    filled[y * STORE_DIM + x] = 1'b1;
    pending_reqs.push_back(r);
    items_issued++;
  endtask

  task automatic touch(input int x, input int y);
    if (!filled[y * STORE_DIM + x]) add_write(x, y, pick_depth(), pick_empty());
  endtask

  // Write every pixel the query may read, then issue the query
  task automatic add_query(input int x, input int y);
    pixel_req_t r;
    int weff, heff, dx, dy, sx, sy;
    weff = eff_dim(img_w);
    heff = eff_dim(img_h);
    if (x < weff && y < heff) begin
      touch(x, y);
      for (int d = 0; d < 8; d++) begin
        for (int s = 0; s < 8; s++) begin
          ring_offset(d, s, dx, dy);
          sx = x + dx;
          sy = y + dy;
          if (sx >= 0 && sy >= 0 && sx < weff && sy < heff) touch(sx, sy);
        end
      end
    end
    r.kind = KIND_QUERY;
    r.x = POS_W'(x);
    r.y = POS_W'(y);
    r.depth = $urandom;
    r.empty = $urandom_range(0, 1);
    pending_reqs.push_back(r);
    items_issued++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:    img_w = value[DIM_CFG_W-1:0];
      REG_HEIGHT:   img_h = value[DIM_CFG_W-1:0];
      REG_THRESH:   thresh = value;
      REG_STRENGTH: strength = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every request is taken and every answer is back, then let the block go quiet
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(STORE_DIM + 1, 1023));
      2: return CFG_DATA_W'(STORE_DIM);
      3: return CFG_DATA_W'($urandom_range(REGION + 1, STORE_DIM - 1));
      default: return CFG_DATA_W'($urandom_range(1, REGION));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_thresh();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5, 6: return CFG_DATA_W'($urandom_range(0, 200));
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_strength();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One random setting of the registers, then a mix of queries and rewrites
  task automatic random_phase(input int n_items);
    int weff, heff, span_x, span_y, r, x, y, first;
    write_reg(REG_WIDTH, pick_dim());
    write_reg(REG_HEIGHT, pick_dim());
    write_reg(REG_THRESH, pick_thresh());
    write_reg(REG_STRENGTH, pick_strength());
    weff = eff_dim(img_w);
    heff = eff_dim(img_h);
    span_x = (weff < REGION) ? weff : REGION;
    span_y = (heff < REGION) ? heff : REGION;
    first = items_issued;
    while (items_issued - first < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65 && span_x > 0 && span_y > 0) begin
        add_query($urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1));
      end else if (r < 78) begin
        if (weff < STORE_DIM && (heff == STORE_DIM || $urandom_range(0, 1) == 1)) begin
          x = $urandom_range(weff, STORE_DIM - 1);
          y = $urandom_range(0, STORE_DIM - 1);
        end else if (heff < STORE_DIM) begin
          x = $urandom_range(0, STORE_DIM - 1);
          y = $urandom_range(heff, STORE_DIM - 1);
        end else begin
          x = $urandom_range(0, REGION - 1);
          y = $urandom_range(0, REGION - 1);
        end
        add_query(x, y);
      end else if (r < 92) begin
        add_write($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1), pick_depth(),
                  pick_empty());
      end else begin
        add_write($urandom_range(0, STORE_DIM - 1), $urandom_range(0, STORE_DIM - 1),
                  $urandom, $urandom_range(0, 1));
      end
    end
  endtask

  // Driver: present the next request once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) commit_request(cur_req);
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_kind <= cur_req.kind;
        in_pos_x <= cur_req.x;
        in_pos_y <= cur_req.y;
        in_depth_value <= cur_req.depth;
        in_is_empty <= cur_req.empty;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Checker: match each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result.ao = out_ao_intensity;
      got_result.occ = out_occluded_count;
      got_result.cnt = out_sample_count;
      if (expected_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: ao=%0d occluded=%0d samples=%0d",
                   got_result.ao, got_result.occ, got_result.cnt);
        mismatches++;
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.ao !== want_result.ao || got_result.occ !== want_result.occ ||
            got_result.cnt !== want_result.cnt) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: expected ao=%0d occluded=%0d samples=%0d, got ao=%0d %s",
                     want_result.ao, want_result.occ, want_result.cnt, got_result.ao,
                     $sformatf("occluded=%0d samples=%0d", got_result.occ, got_result.cnt));
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    depth_base = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: extreme depths, corners, empty centre, full interior ring
    add_write(0, 0, 32'h7fff_ffff, 1'b0);
    add_query(0, 0);
    add_write(STORE_DIM - 1, STORE_DIM - 1, 32'h8000_0000, 1'b0);
    add_query(STORE_DIM - 1, STORE_DIM - 1);
    add_write(STORE_DIM - 1, 0, 32'h0, 1'b1);
    add_query(STORE_DIM - 1, 0);
    add_query(0, STORE_DIM - 1);
    add_query(20, 20);
    settle();

    // Image with no pixels
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, 16'd1023);
    add_query(0, 0);
    add_query(STORE_DIM - 1, STORE_DIM - 1);
    settle();

    // Single pixel image: no sample counts, zero threshold, full strength
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd1);
    write_reg(REG_THRESH, '0);
    write_reg(REG_STRENGTH, '1);
    add_query(0, 0);
    settle();

    // Oversized registers clamp to the store size
    write_reg(REG_WIDTH, 16'd1023);
    write_reg(REG_HEIGHT, 16'd600);
    add_write(10, 10, 32'h7fff_ffff, 1'b0);
    add_query(10, 10);
    add_query(20, 20);
    settle();

    // Centre outside the image, largest threshold, zero strength
    write_reg(REG_WIDTH, 16'd16);
    write_reg(REG_HEIGHT, 16'd16);
    write_reg(REG_THRESH, '1);
    write_reg(REG_STRENGTH, '0);
    add_query(100, 3);
    add_query(3, 100);
    add_query(15, 15);
    add_query(8, 8);
    settle();

    // Random phases; one runs without idling, one holds the receiver off
    phase_no = 0;
    while (items_issued < ITEM_TARGET) begin
      if (phase_no == 2) steady <= 1'b1;
      if (phase_no == 3) steady <= 1'b0;
      if (phase_no == 4) hold_req <= 1'b1;
      random_phase(PHASE_ITEMS);
      settle();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
